// ===== sv/btop_pkg.sv =====
package btop_pkg;

    // tree size and price format
    localparam int MAX_STEPS  = 1023;
    localparam int PRICE_BITS = 32;
    localparam int NODE_AW    = $clog2(MAX_STEPS + 1);
    localparam int CNT_W      = NODE_AW + 1;

    // fixed field widths
    localparam int PRICE_W = 32;
    localparam int STEPS_W = 10;
    localparam int KIND_W  = 2;
    localparam int PROB_W  = 17;
    localparam int IDX_W   = 3;

    localparam logic [PROB_W-1:0] ONE_Q16 = PROB_W'(65536);

    localparam logic [PRICE_W-1:0] PRICE_MASK =
        (PRICE_BITS >= PRICE_W) ? {PRICE_W{1'b1}} : PRICE_W'((64'd1 << PRICE_BITS) - 64'd1);

    // configuration register indexes
    localparam logic [IDX_W-1:0] REG_TREE_STEPS      = 3'd0;
    localparam logic [IDX_W-1:0] REG_PAYOFF_KIND     = 3'd1;
    localparam logic [IDX_W-1:0] REG_STRIKE_PRICE    = 3'd2;
    localparam logic [IDX_W-1:0] REG_BARRIER_LOW     = 3'd3;
    localparam logic [IDX_W-1:0] REG_BARRIER_HIGH    = 3'd4;
    localparam logic [IDX_W-1:0] REG_UP_PROBABILITY  = 3'd5;
    localparam logic [IDX_W-1:0] REG_DISCOUNT_FACTOR = 3'd6;

    // payoff kinds
    localparam logic [KIND_W-1:0] PAY_CALL    = 2'd0;
    localparam logic [KIND_W-1:0] PAY_PUT     = 2'd1;
    localparam logic [KIND_W-1:0] PAY_DIGITAL = 2'd2;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [PRICE_W-1:0] strike;
        logic [PRICE_W-1:0] barrier_low;
        logic [PRICE_W-1:0] barrier_high;
    } payoff_cfg_t;

endpackage

// ===== sv/binomial_tree_option_pricer_core.sv =====
// binomial (cox-ross-rubinstein) european option pricer, backward induction
// input channel s_*: one item per terminal stock price, node 0 first, n+1 items
//   per option where n is tree_steps; each leaf's payoff is stored in a node ram
// result channel m_*: one item per option, the discounted root value (q16.16)
// config channel cfg_*: always ready, index 0..6 selects the register, write
//   only while idle; index 7 is ignored
// timing: a leaf that does not complete the tree is stored and the input
//   stays ready for the next one; the last leaf starts the fold, which runs
//   one shared multiplier twice per node over a five-step sequence (read, mix
//   multiply, add, discount multiply, write) plus one ram read per level; a
//   one-leaf tree (n = 0) gives its result straight after the item, with no
//   fold
// the input is not ready during the fold; it takes leaves of the next tree
//   while a result waits, but holds off the leaf that would finish a tree
//   until the pending result has been taken
// reset: registers return to their default values, the leaf count clears,
//   no result is pending; the node ram is not cleared, nothing reads an
//   entry before the current tree has written it
module binomial_tree_option_pricer_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    // leaf item channel
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [btop_pkg::PRICE_W-1:0]   s_leaf_price,
    // result item channel
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [btop_pkg::PRICE_W-1:0]   m_option_value,
    // configuration write channel
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [btop_pkg::IDX_W-1:0]     cfg_index,
    input  logic [btop_pkg::PRICE_W-1:0]   cfg_data
);

    localparam int AW  = btop_pkg::NODE_AW;
    localparam int CW  = btop_pkg::CNT_W;
    localparam int PW  = btop_pkg::PRICE_W;
    localparam int QW  = btop_pkg::PROB_W;
    localparam int MAW = QW + 1;        // multiplier operand a, signed
    localparam int MBW = PW + 1;        // multiplier operand b, signed
    localparam int MPW = MAW + MBW;     // product width

    // sequencer states
    localparam logic [2:0] ST_LOAD = 3'd0;  // taking leaves
    localparam logic [2:0] ST_RD0  = 3'd1;  // read node 0 of a new level
    localparam logic [2:0] ST_RD   = 3'd2;  // read upper node i+1
    localparam logic [2:0] ST_MIX  = 3'd3;  // q * (upper - lower)
    localparam logic [2:0] ST_SUM  = 3'd4;  // lower + product >> 16
    localparam logic [2:0] ST_DISC = 3'd5;  // mix * discount
    localparam logic [2:0] ST_WR   = 3'd6;  // write node i back

    // configuration registers
    logic [btop_pkg::STEPS_W-1:0] tree_steps_reg;
    logic [btop_pkg::KIND_W-1:0]  payoff_kind_reg;
    logic [PW-1:0]                strike_price_reg;
    logic [PW-1:0]                barrier_low_reg;
    logic [PW-1:0]                barrier_high_reg;
    logic [QW-1:0]                up_probability_reg;
    logic [QW-1:0]                discount_factor_reg;

    // control state
    logic [2:0]    state_reg, state_next;
    logic [CW-1:0] loaded_reg, loaded_next;
    logic [AW-1:0] lvl_reg, lvl_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic          m_valid_reg, m_valid_next;

    // datapath registers
    logic [PW-1:0]         m_data_reg, m_data_next;
    logic [PW-1:0]         low_reg, low_next;
    logic [PW-1:0]         up_reg, up_next;
    logic [PW-1:0]         mix_reg, mix_next;
    logic [QW-1:0]         q_reg, q_next;
    logic [QW-1:0]         d_reg, d_next;
    logic [PW-1:0]         rdata_reg;
    logic signed [MPW-1:0] prod_reg;

    // node ram
    logic [PW-1:0] node_mem [0:btop_pkg::MAX_STEPS];
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [PW-1:0] mem_wdata;
    logic [AW-1:0] mem_raddr;

    logic [AW-1:0]         n_steps;
    logic [CW-1:0]         slot;
    logic                  last_leaf;
    logic                  s_accept;
    logic [PW-1:0]         payoff;
    btop_pkg::payoff_cfg_t pay_cfg;
    logic signed [MAW-1:0] mul_a;
    logic signed [MBW-1:0] mul_b;
    logic signed [MPW-1:0] prod_sh;
    logic [PW-1:0]         disc_val;
    logic [QW-1:0]         q_clamp;
    logic [QW-1:0]         d_clamp;

    // ---------------------------------------------------------------
    // configuration port
    // ---------------------------------------------------------------
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tree_steps_reg      <= btop_pkg::STEPS_W'(10);
            payoff_kind_reg     <= btop_pkg::PAY_CALL;
            strike_price_reg    <= PW'(6553600);
            barrier_low_reg     <= PW'(3276800);
            barrier_high_reg    <= PW'(9830400);
            up_probability_reg  <= QW'(32768);
            discount_factor_reg <= btop_pkg::ONE_Q16;
        end else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                btop_pkg::REG_TREE_STEPS:
                    tree_steps_reg <= cfg_data[btop_pkg::STEPS_W-1:0];
                btop_pkg::REG_PAYOFF_KIND:
                    payoff_kind_reg <= cfg_data[btop_pkg::KIND_W-1:0];
                btop_pkg::REG_STRIKE_PRICE:    strike_price_reg    <= cfg_data;
                btop_pkg::REG_BARRIER_LOW:     barrier_low_reg     <= cfg_data;
                btop_pkg::REG_BARRIER_HIGH:    barrier_high_reg    <= cfg_data;
                btop_pkg::REG_UP_PROBABILITY:  up_probability_reg  <= cfg_data[QW-1:0];
                btop_pkg::REG_DISCOUNT_FACTOR: discount_factor_reg <= cfg_data[QW-1:0];
                default: begin
                end
            endcase
        end
    end

    // tree size clamped to what the node ram holds
    assign n_steps = (32'(tree_steps_reg) > 32'(btop_pkg::MAX_STEPS))
                   ? AW'(btop_pkg::MAX_STEPS) : AW'(tree_steps_reg);

    // probability and discount saturate at one
    assign q_clamp = (up_probability_reg > btop_pkg::ONE_Q16)
                   ? btop_pkg::ONE_Q16 : up_probability_reg;
    assign d_clamp = (discount_factor_reg > btop_pkg::ONE_Q16)
                   ? btop_pkg::ONE_Q16 : discount_factor_reg;

    // ---------------------------------------------------------------
    // leaf loading
    // ---------------------------------------------------------------
    assign pay_cfg.kind         = payoff_kind_reg;
    assign pay_cfg.strike       = strike_price_reg;
    assign pay_cfg.barrier_low  = barrier_low_reg;
    assign pay_cfg.barrier_high = barrier_high_reg;

    btop_payoff u_payoff (
        .leaf_price (s_leaf_price),
        .cfg        (pay_cfg),
        .payoff     (payoff)
    );

    // a partial tree longer than the current size is dropped: restart at leaf 0
    assign slot      = (loaded_reg > CW'(n_steps)) ? '0 : loaded_reg;
    assign last_leaf = (slot == CW'(n_steps));

    // a finishing leaf must not overrun a result still waiting
    assign s_ready  = (state_reg == ST_LOAD) && (!m_valid_reg || !last_leaf);
    assign s_accept = s_valid && s_ready;

    // ---------------------------------------------------------------
    // shared multiplier: q*(upper-lower) then mix*discount
    // ---------------------------------------------------------------
    always_comb begin
        if (state_reg == ST_MIX) begin
            mul_a = signed'({1'b0, q_reg});
            mul_b = signed'({1'b0, rdata_reg}) - signed'({1'b0, low_reg});
        end else begin
            mul_a = signed'({1'b0, d_reg});
            mul_b = signed'({1'b0, mix_reg});
        end
    end

    // (q*up + (1-q)*low) >> 16 == low + floor(q*(up-low) / 65536)
    assign prod_sh  = prod_reg >>> 16;
    assign disc_val = prod_reg[PW+15:16];

    // ---------------------------------------------------------------
    // sequencer
    // ---------------------------------------------------------------
    always_comb begin
        state_next   = state_reg;
        loaded_next  = loaded_reg;
        lvl_next     = lvl_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        low_next     = low_reg;
        up_next      = up_reg;
        mix_next     = mix_reg;
        q_next       = q_reg;
        d_next       = d_reg;
        mem_we       = 1'b0;
        mem_waddr    = slot[AW-1:0];
        mem_wdata    = payoff;
        mem_raddr    = '0;

        if (m_valid_reg && m_ready) m_valid_next = 1'b0;

        case (state_reg)
            ST_LOAD: begin
                if (s_accept) begin
                    mem_we = 1'b1;
                    if (last_leaf) begin
                        loaded_next = '0;
                        if (n_steps == '0) begin
                            // single leaf: the result is the leaf's payoff
                            m_valid_next = 1'b1;
                            m_data_next  = payoff;
                        end else begin
                            lvl_next   = n_steps;
                            idx_next   = '0;
                            q_next     = q_clamp;
                            d_next     = d_clamp;
                            state_next = ST_RD0;
                        end
                    end else begin
                        loaded_next = slot + 1'b1;
                    end
                end
            end
            ST_RD0: begin
                mem_raddr  = '0;
                state_next = ST_RD;
            end
            ST_RD: begin
                mem_raddr = AW'(idx_reg + 1'b1);
                if (idx_reg == '0) low_next = rdata_reg;
                state_next = ST_MIX;
            end
            ST_MIX: begin
                up_next    = rdata_reg;
                state_next = ST_SUM;
            end
            ST_SUM: begin
                mix_next   = low_reg + prod_sh[PW-1:0];
                state_next = ST_DISC;
            end
            ST_DISC: begin
                state_next = ST_WR;
            end
            ST_WR: begin
                mem_we    = 1'b1;
                mem_waddr = idx_reg;
                mem_wdata = disc_val;
                low_next  = up_reg;
                if (AW'(idx_reg + 1'b1) == lvl_reg) begin
                    if (lvl_reg == AW'(1)) begin
                        // root reached
                        m_valid_next = 1'b1;
                        m_data_next  = disc_val;
                        state_next   = ST_LOAD;
                    end else begin
                        lvl_next   = lvl_reg - 1'b1;
                        idx_next   = '0;
                        state_next = ST_RD0;
                    end
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_LOAD;
            loaded_reg  <= '0;
            lvl_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            loaded_reg  <= loaded_next;
            lvl_reg     <= lvl_next;
            idx_reg     <= idx_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        low_reg    <= low_next;
        up_reg     <= up_next;
        mix_reg    <= mix_next;
        q_reg      <= q_next;
        d_reg      <= d_next;
        prod_reg   <= mul_a * mul_b;
    end

    // node ram, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) node_mem[mem_waddr] <= mem_wdata;
        rdata_reg <= node_mem[mem_raddr];
    end

    assign m_valid        = m_valid_reg;
    assign m_option_value = m_data_reg;

endmodule

// ===== sv/btop_payoff.sv =====
module btop_payoff (
    input  logic [btop_pkg::PRICE_W-1:0] leaf_price,
    input  btop_pkg::payoff_cfg_t        cfg,
    output logic [btop_pkg::PRICE_W-1:0] payoff
);

    logic [btop_pkg::PRICE_W-1:0] z;

    assign z = leaf_price & btop_pkg::PRICE_MASK;

    always_comb begin
        payoff = '0;
        case (cfg.kind)
            btop_pkg::PAY_CALL: begin
                if (z > cfg.strike) payoff = z - cfg.strike;
            end
            btop_pkg::PAY_PUT: begin
                if (z < cfg.strike) payoff = cfg.strike - z;
            end
            btop_pkg::PAY_DIGITAL: begin
                // pays one only strictly inside the barriers
                if ((z > cfg.barrier_low) && (z < cfg.barrier_high))
                    payoff = btop_pkg::PRICE_W'(btop_pkg::ONE_Q16);
            end
            default: begin
                payoff = '0;
            end
        endcase
    end

endmodule

// ===== sv/btop_checker.sv =====
module btop_checker (
    input logic                         aclk,
    input logic                         aresetn,
    input logic                         s_valid,
    input logic                         s_ready,
    input logic                         m_valid,
    input logic                         m_ready,
    input logic [btop_pkg::PRICE_W-1:0] m_option_value
);

    // a stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_option_value))
        else $error("result dropped or changed while stalled");

    // nothing pending straight after reset
    assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result pending after reset");

    // a result appears only after an item or after a fold with input held off
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready) || $past(!s_ready))
        else $error("result appeared without an item or a fold");

    // the leaf that finishes a tree is never taken while a result waits and stalls
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready && s_valid && s_ready |=> m_valid && $stable(m_option_value))
        else $error("pending result overwritten by a new item");

endmodule

bind binomial_tree_option_pricer_core btop_checker u_btop_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_option_value (m_option_value)
);

// ===== bench/binomial_tree_option_pricer_core_tb.sv =====
`timescale 1ns / 1ps

module binomial_tree_option_pricer_core_tb;

    // clocking and run length
    localparam int CLK_HALF          = 5;
    localparam int RESET_CYCLES      = 12;
    localparam int RANDOM_ITEMS      = 420;
    localparam int SETTLE_CYCLES     = 8;
    localparam int unsigned CYCLE_LIMIT = 1_000_000;

    // codes the package leaves unnamed
    localparam logic [btop_pkg::IDX_W-1:0]  REG_SPARE = 3'd7;   // index the block ignores
    localparam logic [btop_pkg::KIND_W-1:0] PAY_NONE  = 2'd3;   // kind that pays nothing

    typedef enum logic {ROW_WRITE, ROW_LEAF} row_kind_t;

    // one row of the directed table: a register write or a leaf item,
    // with the root value typed in where it is obvious
    typedef struct {
        row_kind_t                      kind;
        logic [btop_pkg::IDX_W-1:0]     index;
        logic [btop_pkg::PRICE_W-1:0]   data;
        bit                             known;
        logic [btop_pkg::PRICE_W-1:0]   value;
    } stim_row_t;

    typedef struct {
        bit                             known;
        logic [btop_pkg::PRICE_W-1:0]   value;
    } leaf_note_t;

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [btop_pkg::PRICE_W-1:0]   s_leaf_price = '0;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic [btop_pkg::PRICE_W-1:0]   m_option_value;
    logic                           cfg_valid = 1'b0;
    logic                           cfg_ready;
    logic [btop_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [btop_pkg::PRICE_W-1:0]   cfg_data = '0;

    binomial_tree_option_pricer_core dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_leaf_price   (s_leaf_price),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_option_value (m_option_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // idling, in percent of cycles; the first setting covers the directed part
    int tx_idle_pct = 37;
    int rx_idle_pct = 80;

    // receiver: stalls at random, regardless of whether a result is waiting
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
    end

    int unsigned cycle_count = 0;
    int          mismatch_count = 0;

    // watchdog, well clear of the slowest legal run
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // pricing model: register copies at their reset values, node store
    // and the count of leaves loaded into the current tree
    // ------------------------------------------------------------------
    logic [btop_pkg::STEPS_W-1:0] steps_reg        = 10'd10;
    logic [btop_pkg::KIND_W-1:0]  kind_reg         = btop_pkg::PAY_CALL;
    logic [btop_pkg::PRICE_W-1:0] strike_reg       = 32'd6553600;    // 100.0
    logic [btop_pkg::PRICE_W-1:0] barrier_low_reg  = 32'd3276800;    // 50.0
    logic [btop_pkg::PRICE_W-1:0] barrier_high_reg = 32'd9830400;    // 150.0
    logic [btop_pkg::PROB_W-1:0]  up_prob_reg      = 17'd32768;      // 0.5
    logic [btop_pkg::PROB_W-1:0]  discount_reg     = 17'd65536;      // 1.0

    logic [btop_pkg::PRICE_W-1:0] node_value [0:btop_pkg::MAX_STEPS];
    int                           leaf_count = 0;

    // root values still owed by the block, oldest first
    logic [btop_pkg::PRICE_W-1:0] due_values [$];
    // one note per leaf item on its way in, carrying any typed-in root value
    leaf_note_t                   leaf_notes [$];

    function automatic int eff_steps();
        return (steps_reg > btop_pkg::MAX_STEPS) ? btop_pkg::MAX_STEPS : int'(steps_reg);
    endfunction

    // leaves still to send before the current tree folds
    function automatic int leaves_needed();
        int n;
        n = eff_steps();
        return (leaf_count > n) ? n + 1 : n + 1 - leaf_count;
    endfunction

    function automatic void load_register(input logic [btop_pkg::IDX_W-1:0] index,
                                          input logic [btop_pkg::PRICE_W-1:0] data);
        case (index)
            btop_pkg::REG_TREE_STEPS:      steps_reg        = data[btop_pkg::STEPS_W-1:0];
            btop_pkg::REG_PAYOFF_KIND:     kind_reg         = data[btop_pkg::KIND_W-1:0];
            btop_pkg::REG_STRIKE_PRICE:    strike_reg       = data;
            btop_pkg::REG_BARRIER_LOW:     barrier_low_reg  = data;
            btop_pkg::REG_BARRIER_HIGH:    barrier_high_reg = data;
            btop_pkg::REG_UP_PROBABILITY:  up_prob_reg      = data[btop_pkg::PROB_W-1:0];
            btop_pkg::REG_DISCOUNT_FACTOR: discount_reg     = data[btop_pkg::PROB_W-1:0];
            default: ;
        endcase
    endfunction

    // stores the leaf's payoff; on the last leaf folds the tree back to the root
    function automatic void take_leaf_price(input logic [btop_pkg::PRICE_W-1:0] price,
                                            output bit done,
                                            output logic [btop_pkg::PRICE_W-1:0] root);
        int                           n;
        logic [btop_pkg::PRICE_W-1:0] z;
        logic [btop_pkg::PRICE_W-1:0] payoff;
        logic [63:0]                  q;
        logic [63:0]                  d;
        logic [63:0]                  mix;
        n = eff_steps();
        z = price & btop_pkg::PRICE_MASK;
        done = 1'b0;
        root = '0;
        // tree shrunk below the leaves already held: start afresh
        if (leaf_count > n)
            leaf_count = 0;
        case (kind_reg)
            btop_pkg::PAY_CALL:    payoff = (z > strike_reg) ? z - strike_reg : '0;
            btop_pkg::PAY_PUT:     payoff = (z < strike_reg) ? strike_reg - z : '0;
            btop_pkg::PAY_DIGITAL: payoff = (barrier_low_reg < z && z < barrier_high_reg) ?
                                            btop_pkg::PRICE_W'(btop_pkg::ONE_Q16) : '0;
            default:               payoff = '0;
        endcase
        node_value[leaf_count] = payoff;
        leaf_count++;
        if (leaf_count < n + 1)
            return;
        // probability and discount saturate at one
        q = (up_prob_reg > btop_pkg::ONE_Q16) ? 64'(btop_pkg::ONE_Q16) : 64'(up_prob_reg);
        d = (discount_reg > btop_pkg::ONE_Q16) ? 64'(btop_pkg::ONE_Q16) : 64'(discount_reg);
        for (int lvl = n; lvl > 0; lvl--) begin
            for (int i = 0; i < lvl; i++) begin
                mix = (q * node_value[i + 1]
                       + (64'(btop_pkg::ONE_Q16) - q) * node_value[i]) >> 16;
                node_value[i] = btop_pkg::PRICE_W'((mix * d) >> 16);
            end
        end
        root = node_value[0];
        leaf_count = 0;
        done = 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at cycle %0d: %s", cycle_count, what);
        mismatch_count++;
    endtask

    // ------------------------------------------------------------------
    // monitor: all three channels sampled at the edge, before any update
    // ------------------------------------------------------------------
    leaf_note_t                   seen_note;
    bit                           root_ready;
    logic [btop_pkg::PRICE_W-1:0] root_value;
    logic [btop_pkg::PRICE_W-1:0] due_value;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                load_register(cfg_index, cfg_data);
            if (s_valid && s_ready) begin
                seen_note = leaf_notes.pop_front();
                take_leaf_price(s_leaf_price, root_ready, root_value);
                // a typed-in value takes the place of the model's
                if (root_ready)
                    due_values.push_back(seen_note.known ? seen_note.value : root_value);
            end
            if (m_valid && m_ready) begin
                if (due_values.size() == 0) begin
                    report_mismatch($sformatf("option_value %h with nothing owed",
                                              m_option_value));
                end else begin
                    due_value = due_values.pop_front();
                    if (m_option_value !== due_value)
                        report_mismatch($sformatf("option_value %h, wanted %h",
                                                  m_option_value, due_value));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one leaf item: random gap, then valid held until taken
    task automatic send_leaf(input logic [btop_pkg::PRICE_W-1:0] price, input bit known,
                             input logic [btop_pkg::PRICE_W-1:0] value);
        int         gap;
        leaf_note_t note;
        gap = 0;
        while ($urandom_range(99) < tx_idle_pct)
            gap++;
        note.known = known;
        note.value = value;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        leaf_notes.push_back(note);
        s_valid      <= 1'b1;
        s_leaf_price <= price;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_reg(input logic [btop_pkg::IDX_W-1:0] index,
                             input logic [btop_pkg::PRICE_W-1:0] data);
        cfg_index <= index;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge aclk);
    endtask

    // sender holds off until every owed root has come out, then a short settle
    task automatic drain_results();
        s_valid <= 1'b0;
        do @(posedge aclk); while (due_values.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // leaf price: mostly close to the strike or the barriers, some noise
    function automatic logic [btop_pkg::PRICE_W-1:0] pick_price();
        int          r;
        logic [63:0] centre;
        logic [63:0] spread;
        logic [63:0] v;
        r = $urandom_range(99);
        if (r < 12)
            return $urandom;
        if (r < 16)
            return r[0] ? '1 : '0;
        if (r < 24) begin
            // land exactly on a threshold
            case (r % 3)
                0:       return strike_reg;
                1:       return barrier_low_reg;
                default: return barrier_high_reg;
            endcase
        end
        centre = (kind_reg == btop_pkg::PAY_DIGITAL) ?
                 (64'(barrier_low_reg) + 64'(barrier_high_reg)) / 2 : 64'(strike_reg);
        spread = 64'd1 << $urandom_range(4, 22);
        v = centre + 64'($urandom_range(0, 32'(2 * spread)));
        if (v < spread)
            return '0;
        v = v - spread;
        return (v > 64'hFFFF_FFFF) ? '1 : v[btop_pkg::PRICE_W-1:0];
    endfunction

    // random register set; every register when everything is asked for
    task automatic shuffle_settings(input bit everything);
        int                           r;
        logic [btop_pkg::PRICE_W-1:0] value;
        if (everything || $urandom_range(99) < 60) begin
            r = $urandom_range(99);
            // small trees mostly, the fold time grows with the square of the size
            if (r < 70)
                value = $urandom_range(0, 8);
            else if (r < 95)
                value = $urandom_range(9, 24);
            else
                value = $urandom_range(25, 48);
            if ($urandom_range(9) == 0)
                value = value | ($urandom << btop_pkg::STEPS_W);    // bits above the field
            write_reg(btop_pkg::REG_TREE_STEPS, value);
        end
        if (everything || $urandom_range(99) < 40) begin
            value = ($urandom_range(9) == 0) ? 32'(PAY_NONE) : $urandom_range(0, 2);
            if ($urandom_range(9) == 0)
                value = value | ($urandom << btop_pkg::KIND_W);
            write_reg(btop_pkg::REG_PAYOFF_KIND, value);
        end
        if (everything || $urandom_range(99) < 40) begin
            r = $urandom_range(99);
            value = (r < 5) ? '0 : (r < 10) ? '1 : (r < 20) ? $urandom :
                    $urandom_range(32'h0001_0000, 32'h0FFF_FFFF);
            write_reg(btop_pkg::REG_STRIKE_PRICE, value);
        end
        if (everything || $urandom_range(99) < 30) begin
            r = $urandom_range(99);
            value = (r < 5) ? '0 : (r < 10) ? '1 : (r < 20) ? $urandom :
                    $urandom_range(32'h0001_0000, 32'h0FFF_FFFF);
            write_reg(btop_pkg::REG_BARRIER_LOW, value);
            r = $urandom_range(99);
            // above the low barrier by a modest margin, else anywhere at all
            if (r < 5)
                value = '0;
            else if (r < 10)
                value = '1;
            else if (r < 25)
                value = $urandom;
            else if (64'(barrier_low_reg) + 64'h0040_0000 > 64'hFFFF_FFFF)
                value = '1;
            else
                value = barrier_low_reg + $urandom_range(0, 32'h0040_0000);
            write_reg(btop_pkg::REG_BARRIER_HIGH, value);
        end
        if (everything || $urandom_range(99) < 40) begin
            r = $urandom_range(99);
            value = (r < 5) ? '0 : (r < 10) ? 32'(btop_pkg::ONE_Q16) :
                    (r < 15) ? $urandom_range(65537, 32'h1FFFF) : $urandom_range(0, 65536);
            if ($urandom_range(9) == 0)
                value = value | ($urandom << btop_pkg::PROB_W);
            write_reg(btop_pkg::REG_UP_PROBABILITY, value);
        end
        if (everything || $urandom_range(99) < 40) begin
            r = $urandom_range(99);
            value = (r < 5) ? '0 : (r < 10) ? 32'(btop_pkg::ONE_Q16) :
                    (r < 15) ? $urandom_range(65537, 32'h1FFFF) : $urandom_range(60000, 65536);
            if ($urandom_range(9) == 0)
                value = value | ($urandom << btop_pkg::PROB_W);
            write_reg(btop_pkg::REG_DISCOUNT_FACTOR, value);
        end
    endtask

    // ------------------------------------------------------------------
    // directed table
    // ------------------------------------------------------------------
    stim_row_t stim_rows [$];

    function automatic void add_write(input logic [btop_pkg::IDX_W-1:0] index,
                                      input logic [btop_pkg::PRICE_W-1:0] data);
        stim_row_t row;
        row.kind  = ROW_WRITE;
        row.index = index;
        row.data  = data;
        row.known = 1'b0;
        row.value = '0;
        stim_rows.push_back(row);
    endfunction

    function automatic void add_leaf(input logic [btop_pkg::PRICE_W-1:0] price,
                                     input bit known,
                                     input logic [btop_pkg::PRICE_W-1:0] value);
        stim_row_t row;
        row.kind  = ROW_LEAF;
        row.index = '0;
        row.data  = price;
        row.known = known;
        row.value = value;
        stim_rows.push_back(row);
    endfunction

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial begin
        int r;
        int k;
        int loaded;
        int leaves_to_go;
        int random_items;

        // reset settings: ten steps, call at 100.0, q one half, no discount;
        // eleven equal leaves at 110.0 fold to exactly 10.0
        for (int i = 0; i < 10; i++)
            add_leaf(32'd7208960, 1'b0, '0);
        add_leaf(32'd7208960, 1'b1, 32'd655360);
        // the spare index must leave every register alone
        add_write(REG_SPARE, 32'hFFFF_FFFF);
        // single leaf trees give the payoff straight back
        add_write(btop_pkg::REG_TREE_STEPS, 32'd0);
        add_leaf(32'hFFFF_FFFF, 1'b1, 32'hFF9B_FFFF);
        add_write(btop_pkg::REG_PAYOFF_KIND, 32'(btop_pkg::PAY_PUT));
        add_leaf(32'd0, 1'b1, 32'd6553600);
        add_write(btop_pkg::REG_STRIKE_PRICE, 32'hFFFF_FFFF);
        add_leaf(32'd0, 1'b1, 32'hFFFF_FFFF);
        // digital pays only strictly between the barriers
        add_write(btop_pkg::REG_PAYOFF_KIND, 32'(btop_pkg::PAY_DIGITAL));
        add_leaf(32'd3276800, 1'b1, 32'd0);
        add_leaf(32'd3276801, 1'b1, 32'd65536);
        add_leaf(32'd9830400, 1'b1, 32'd0);
        // unknown kind pays nothing
        add_write(btop_pkg::REG_PAYOFF_KIND, 32'(PAY_NONE));
        add_leaf(32'd7208960, 1'b1, 32'd0);
        // one step, call at zero strike, probability and discount above one
        add_write(btop_pkg::REG_PAYOFF_KIND, 32'(btop_pkg::PAY_CALL));
        add_write(btop_pkg::REG_STRIKE_PRICE, 32'd0);
        add_write(btop_pkg::REG_TREE_STEPS, 32'd1);
        add_write(btop_pkg::REG_UP_PROBABILITY, 32'h0001_FFFF);
        add_write(btop_pkg::REG_DISCOUNT_FACTOR, 32'h0001_FFFF);
        add_leaf(32'h1234_5678, 1'b0, '0);
        add_leaf(32'hFFFF_FFFF, 1'b1, 32'hFFFF_FFFF);
        // zero probability keeps the lower node
        add_write(btop_pkg::REG_UP_PROBABILITY, 32'd0);
        add_leaf(32'hDEAD_BEEF, 1'b0, '0);
        add_leaf(32'd7, 1'b1, 32'hDEAD_BEEF);
        // largest tree, part loaded, then shrunk under the loaded count
        add_write(btop_pkg::REG_TREE_STEPS, 32'd1023);
        add_leaf(32'h0005_0000, 1'b0, '0);
        add_leaf(32'h0006_0000, 1'b0, '0);
        add_leaf(32'h0007_0000, 1'b0, '0);
        add_write(btop_pkg::REG_TREE_STEPS, 32'd1);
        add_leaf(32'h0001_0000, 1'b0, '0);
        add_leaf(32'h0003_0000, 1'b0, '0);
        // zero discount wipes the root
        add_write(btop_pkg::REG_DISCOUNT_FACTOR, 32'd0);
        add_leaf(32'hFFFF_FFFF, 1'b0, '0);
        add_leaf(32'hFFFF_FFFF, 1'b1, 32'd0);

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        foreach (stim_rows[i]) begin
            if (stim_rows[i].kind == ROW_WRITE) begin
                drain_results();
                write_reg(stim_rows[i].index, stim_rows[i].data);
            end else begin
                send_leaf(stim_rows[i].data, stim_rows[i].known, stim_rows[i].value);
            end
        end

        // random part: whole trees mostly, with settings changes, broken trees
        // and shrinks between them
        drain_results();
        shuffle_settings(1'b1);
        leaves_to_go = leaves_needed();
        random_items = 0;
        while (random_items < RANDOM_ITEMS) begin
            // idling swaps sides after a third, then stops
            if (random_items < RANDOM_ITEMS / 3) begin
                tx_idle_pct = 37;
                rx_idle_pct = 80;
            end else if (random_items < 2 * RANDOM_ITEMS / 3) begin
                tx_idle_pct = 80;
                rx_idle_pct = 37;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            r = $urandom_range(99);
            if (r < 25) begin
                drain_results();
                shuffle_settings(1'b0);
                leaves_to_go = leaves_needed();
            end else if (r < 35 && leaves_to_go >= 2) begin
                // broken tree: part of it, then the size moves under it
                k = $urandom_range(1, leaves_to_go - 1);
                for (int j = 0; j < k; j++)
                    send_leaf(pick_price(), 1'b0, '0);
                random_items += k;
                drain_results();
                loaded = leaf_count;
                if ($urandom_range(99) < 60)
                    write_reg(btop_pkg::REG_TREE_STEPS, $urandom_range(0, loaded - 1));
                else
                    write_reg(btop_pkg::REG_TREE_STEPS, $urandom_range(loaded, loaded + 16));
                leaves_to_go = leaves_needed();
            end else begin
                for (int j = 0; j < leaves_to_go; j++)
                    send_leaf(pick_price(), 1'b0, '0);
                random_items += leaves_to_go;
                leaves_to_go = eff_steps() + 1;
            end
        end

        drain_results();
        repeat (SETTLE_CYCLES * 4) @(posedge aclk);
        if (mismatch_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
